// ===== rtl/pcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbd_pkg: shared types and constants of the prefix code bit decoder
// Item and result structs, controller/datapath command and status bundles,
// controller state encoding and the code mask helper.
// ----------------------------------------------------------------------------
package pcbd_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int MAX_CODE_LEN      = 32;
	localparam int CODE_W            = 32;
	localparam int LEN_W             = 6;
	localparam int SYM_W             = 8;
	localparam int IDX_W             = 8;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [SYM_W-1:0]  entry_symbol;
		logic [CODE_W-1:0] entry_code;
		logic [LEN_W-1:0]  entry_length;
		logic              bit_value;
	} pcbd_in_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             overflow_error;
	} pcbd_out_t;

	typedef struct packed {
		logic load;        // write one table entry from the input beat
		logic take_bit;    // shift the new bit in and restart the scan
		logic issue;       // read the table entry at the scan address
		logic emit_hit;    // deliver the matched symbol, clear pending code
		logic emit_err;    // deliver an overflow error, clear pending code
	} pcbd_cmd_t;

	typedef struct packed {
		logic hit;         // the entry in the compare stage matches
		logic last;        // the entry in the compare stage is the final one
		logic over;        // pending length exceeds the longest stored code
	} pcbd_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK
	} pcbd_state_t;

	// Mask that keeps the low len bits of a code word.
	function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] m;
		if (int'(len) >= CODE_W) begin
			m = '1;
		end else begin
			m = (CODE_W'(1) << len) - CODE_W'(1);
		end
		return m;
	endfunction

endpackage

// ===== rtl/prefix_code_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder: bit-serial prefix code decoder
// A beat on the input either loads one code table entry or feeds one
// compressed bit; a decoded symbol or an overflow error comes back as a
// single-cycle result beat.
//
// Usage: present item with start high; the beat is taken at an edge where
// busy is low. A load beat writes the table at that edge and leaves busy low,
// so loads run one per cycle while no decode holds busy. A decode beat raises
// busy while the table is walked one entry per cycle through the single read
// port of the table memory: busy stays high until the matching entry reaches
// the compare stage or, when no entry matches, until the final length check
// after the last entry. A result beat is marked by done for exactly one
// cycle, in the cycle after the match or the final length check; the receiver
// cannot stall it.
// Many decode beats give no result. Reset marks every table entry empty and
// clears the pending code; no clearing pass is needed.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder import pcbd_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  pcbd_in_t  item,
	output logic      done,
	output pcbd_out_t result
);

	pcbd_cmd_t  cmd;
	pcbd_stat_t stat;

	pcbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pcbd_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

// ===== rtl/pcbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcbd_ctrl: controller of the prefix code bit decoder
// Accepts beats, sequences the table scan and decides when a symbol or an
// overflow error is delivered.
// ----------------------------------------------------------------------------
module pcbd_ctrl import pcbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       opcode,
	input  pcbd_stat_t stat,
	output pcbd_cmd_t  cmd,
	output logic       busy
);

	pcbd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && opcode == OP_DECODE) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.hit) begin
					state_d = ST_IDLE;
				end else if (stat.last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load     = (opcode == OP_LOAD);
					cmd.take_bit = (opcode == OP_DECODE);
				end
			end
			ST_SCAN: begin
				cmd.issue    = 1'b1;
				cmd.emit_hit = stat.hit;
			end
			ST_CHECK: begin
				cmd.emit_err = stat.over;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/pcbd_datapath.sv =====
// ----------------------------------------------------------------------------
// pcbd_datapath: table storage, pending code and compare stage
// Holds the code table memories, walks them one entry per cycle through a
// registered read stage, and registers the delivered result.
// ----------------------------------------------------------------------------
module pcbd_datapath import pcbd_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pcbd_in_t   item,
	input  pcbd_cmd_t  cmd,
	output pcbd_stat_t stat,
	output logic       done,
	output pcbd_out_t  result
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	logic [CODE_W-1:0] code_mem [TABLE_ENTRIES];
	logic [LEN_W-1:0]  len_mem  [TABLE_ENTRIES];
	logic [SYM_W-1:0]  sym_mem  [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] written_q;

	logic [AW-1:0]     addr_q;
	logic [CODE_W-1:0] pend_bits_q;
	logic [LEN_W-1:0]  pend_len_q;
	logic [LEN_W-1:0]  longest_q;

	logic [CODE_W-1:0] code_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [SYM_W-1:0]  sym_s1;
	logic              written_s1;
	logic              valid_s1;
	logic              last_s1;

	logic              done_q;
	pcbd_out_t         result_q;

	logic              in_range;
	logic [AW-1:0]     wr_addr;
	logic [LEN_W-1:0]  wr_len;
	logic [LEN_W-1:0]  len_eff;
	logic              match;

	assign in_range = int'(item.entry_index) < TABLE_ENTRIES;
	assign wr_addr  = item.entry_index[AW-1:0];
	assign wr_len   = (int'(item.entry_length) > MAX_CODE_LEN ||
		int'(item.entry_length) > CODE_W) ? '0 : item.entry_length;

	// Table memories: one write port for loads, one registered read for the scan.
	always_ff @(posedge clk) begin
		if (cmd.load && in_range) begin
			code_mem[wr_addr] <= item.entry_code;
			len_mem[wr_addr]  <= wr_len;
			sym_mem[wr_addr]  <= item.entry_symbol;
		end
		if (cmd.issue) begin
			code_s1 <= code_mem[addr_q];
			len_s1  <= len_mem[addr_q];
			sym_s1  <= sym_mem[addr_q];
		end
	end

	// An entry never written reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (cmd.load && in_range) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			written_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (cmd.issue) begin
				written_s1 <= written_q[addr_q];
				last_s1    <= (addr_q == LAST_ADDR);
				addr_q     <= (addr_q == LAST_ADDR) ? '0 : addr_q + AW'(1);
			end else if (cmd.take_bit) begin
				addr_q <= '0;
			end
		end
	end

	assign len_eff = written_s1 ? len_s1 : '0;
	assign match   = (len_eff != '0) && (len_eff == pend_len_q) &&
		(((code_s1 ^ pend_bits_q) & code_mask(len_eff)) == '0);

	assign stat.hit  = valid_s1 && match;
	assign stat.last = valid_s1 && last_s1;
	assign stat.over = pend_len_q > longest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_len_q  <= '0;
			longest_q   <= '0;
		end else begin
			if (cmd.take_bit) begin
				pend_bits_q <= {pend_bits_q[CODE_W-2:0], item.bit_value};
				if (pend_len_q != '1) begin
					pend_len_q <= pend_len_q + LEN_W'(1);
				end
				longest_q <= '0;
			end else if (cmd.emit_hit || cmd.emit_err) begin
				pend_bits_q <= '0;
				pend_len_q  <= '0;
			end
			if (valid_s1 && len_eff > longest_q && !cmd.take_bit) begin
				longest_q <= len_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_hit || cmd.emit_err;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hit) begin
			result_q.symbol         <= sym_s1;
			result_q.overflow_error <= 1'b0;
		end else if (cmd.emit_err) begin
			result_q.symbol         <= '0;
			result_q.overflow_error <= 1'b1;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
